// ----- design/cst_pkg.sv -----
// Shared types, constants, lookup and arithmetic functions of the cone surface tessellator.
`default_nettype none

package cst_pkg;

   localparam int VERTS       = 6;
   localparam int DIV_W       = 43;
   localparam int DEN_W       = 11;
   localparam int CORD_W      = 34;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   localparam logic [CORD_W-1:0] CORDIC_GAIN = 34'd652032874;

   localparam logic [2:0] REG_BASE_RADIUS  = 3'd0;
   localparam logic [2:0] REG_CONE_HEIGHT  = 3'd1;
   localparam logic [2:0] REG_CENTER_X     = 3'd2;
   localparam logic [2:0] REG_CENTER_Y     = 3'd3;
   localparam logic [2:0] REG_CENTER_Z     = 3'd4;
   localparam logic [2:0] REG_THETA_STEPS  = 3'd5;
   localparam logic [2:0] REG_HEIGHT_STEPS = 3'd6;

   typedef struct packed {
      logic [9:0] theta;
      logic [9:0] height;
      logic       err;
   } cell_type;

   typedef struct packed {
      logic vld;
      logic err;
      logic last;
   } div_side_type;

   typedef struct packed {
      logic        vld;
      logic        err;
      logic        last;
      logic [30:0] radius;
      logic [30:0] dz;
   } cord_side_type;

   typedef struct packed {
      logic [14:0] nxy;
      logic [14:0] nz;
   } norm_type;

   typedef enum logic [2:0] {
      NRM_IDLE,
      NRM_LOAD,
      NRM_SHIFT,
      NRM_SQUARE,
      NRM_SUM,
      NRM_SQRT,
      NRM_DIV
   } norm_state_type;

   // Arctangent of 2^-i in units of 2^-32 turn.
   function automatic logic [31:0] atan_turn(input int i);
      logic [31:0] v;
      begin
         unique case (i)
            0: v = 32'h20000000;
            1: v = 32'h12E4051D;
            2: v = 32'h09FB385B;
            3: v = 32'h051111D4;
            4: v = 32'h028B0D43;
            5: v = 32'h0145D7E1;
            6: v = 32'h00A2F61E;
            7: v = 32'h00517C55;
            8: v = 32'h0028BE53;
            9: v = 32'h00145F2E;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2F9;
            15: v = 32'h0000517C;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A2F;
            19: v = 32'h00000517;
            20: v = 32'h0000028B;
            21: v = 32'h00000145;
            22: v = 32'h000000A2;
            23: v = 32'h00000051;
            24: v = 32'h00000028;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000002;
            29: v = 32'h00000001;
            default: v = 32'h00000000;
         endcase
         return v;
      end
   endfunction

   // Corner order 00,10,01,01,10,11: angle offset of vertex k.
   function automatic logic corner_t(input logic [2:0] k);
      logic v;
      begin
         unique case (k)
            3'd1, 3'd4, 3'd5: v = 1'b1;
            default: v = 1'b0;
         endcase
         return v;
      end
   endfunction

   // Height offset of vertex k.
   function automatic logic corner_h(input logic [2:0] k);
      logic v;
      begin
         unique case (k)
            3'd2, 3'd3, 3'd5: v = 1'b1;
            default: v = 1'b0;
         endcase
         return v;
      end
   endfunction

   function automatic logic [31:0] sat32(input logic signed [34:0] v);
      logic [31:0] r;
      begin
         if (v > 35'sd2147483647) begin
            r = 32'h7FFFFFFF;
         end else if (v < -35'sd2147483648) begin
            r = 32'h80000000;
         end else begin
            r = v[31:0];
         end
         return r;
      end
   endfunction

   // Q30 product rounded half up.
   function automatic logic signed [33:0] round_q30(input logic signed [63:0] p);
      logic signed [63:0] t;
      begin
         t = (p + 64'sd536870912) >>> 30;
         return t[33:0];
      end
   endfunction

endpackage

`default_nettype wire

// ----- design/cone_surface_tessellator.sv -----
// The back end issues one vertex per cycle into the divider and CORDIC pipelines while the
// output is not stalled; an in-range cell yields six vertices, an out-of-range cell one.
// Reset and every register write start the normal unit, which skips its computation for a
// cone of zero height and radius; no cell is accepted until it is done. Reset is synchronous
// and active high.
`default_nettype none

module cone_surface_tessellator #(
   parameter int MAX_STEPS     = 1024,
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [9:0]   req_cell_theta,
   input  wire logic [9:0]   req_cell_height,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z,
   output logic signed [15:0] rsp_norm_x,
   output logic signed [15:0] rsp_norm_y,
   output logic signed [15:0] rsp_norm_z,
   output logic              rsp_cell_error,
   output logic              rsp_last_vertex,
   input  wire logic         psel,
   input  wire logic         penable,
   input  wire logic         pwrite,
   input  wire logic [4:0]   paddr,
   input  wire logic [31:0]  pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   logic [30:0] radius_ff;
   logic [30:0] height_ff;
   logic [31:0] cx_ff;
   logic [31:0] cy_ff;
   logic [31:0] cz_ff;
   logic [10:0] tsteps_ff;
   logic [10:0] hsteps_ff;

   logic              wr;
   logic [2:0]        idx;
   logic              norm_busy;
   cst_pkg::norm_type norm;
   logic              q_valid;
   cst_pkg::cell_type q_cell;
   logic              q_pop;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign idx    = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 31'd65536;
         height_ff <= 31'd65536;
         cx_ff     <= '0;
         cy_ff     <= '0;
         cz_ff     <= '0;
         tsteps_ff <= 11'd16;
         hsteps_ff <= 11'd4;
      end else if (wr) begin
         unique case (idx)
            cst_pkg::REG_BASE_RADIUS:  radius_ff <= pwdata[30:0];
            cst_pkg::REG_CONE_HEIGHT:  height_ff <= pwdata[30:0];
            cst_pkg::REG_CENTER_X:     cx_ff     <= pwdata;
            cst_pkg::REG_CENTER_Y:     cy_ff     <= pwdata;
            cst_pkg::REG_CENTER_Z:     cz_ff     <= pwdata;
            cst_pkg::REG_THETA_STEPS:  tsteps_ff <= pwdata[10:0];
            cst_pkg::REG_HEIGHT_STEPS: hsteps_ff <= pwdata[10:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         cst_pkg::REG_BASE_RADIUS:  prdata = {1'b0, radius_ff};
         cst_pkg::REG_CONE_HEIGHT:  prdata = {1'b0, height_ff};
         cst_pkg::REG_CENTER_X:     prdata = cx_ff;
         cst_pkg::REG_CENTER_Y:     prdata = cy_ff;
         cst_pkg::REG_CENTER_Z:     prdata = cz_ff;
         cst_pkg::REG_THETA_STEPS:  prdata = {21'd0, tsteps_ff};
         cst_pkg::REG_HEIGHT_STEPS: prdata = {21'd0, hsteps_ff};
         default:                   prdata = '0;
      endcase
   end

   cst_norm u_norm (
      .clock       (clock),
      .reset       (reset),
      .restart     (wr),
      .cone_height (height_ff),
      .base_radius (radius_ff),
      .busy        (norm_busy),
      .norm        (norm)
   );

   cst_front #(
      .MAX_STEPS (MAX_STEPS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cell_theta  (req_cell_theta),
      .req_cell_height (req_cell_height),
      .theta_steps     (tsteps_ff),
      .height_steps    (hsteps_ff),
      .hold            (norm_busy),
      .q_valid         (q_valid),
      .q_cell          (q_cell),
      .q_pop           (q_pop)
   );

   cst_back #(
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_cell          (q_cell),
      .q_pop           (q_pop),
      .base_radius     (radius_ff),
      .cone_height     (height_ff),
      .center_x        (cx_ff),
      .center_y        (cy_ff),
      .center_z        (cz_ff),
      .theta_steps     (tsteps_ff),
      .height_steps    (hsteps_ff),
      .norm            (norm),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_pos_z       (rsp_pos_z),
      .rsp_norm_x      (rsp_norm_x),
      .rsp_norm_y      (rsp_norm_y),
      .rsp_norm_z      (rsp_norm_z),
      .rsp_cell_error  (rsp_cell_error),
      .rsp_last_vertex (rsp_last_vertex)
   );

endmodule

`default_nettype wire

// ----- design/cst_front.sv -----
// Front end: takes cells, flags out-of-range ones and queues them for the back end.
`default_nettype none

module cst_front #(
   parameter int MAX_STEPS = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [9:0]        req_cell_theta,
   input  wire logic [9:0]        req_cell_height,
   input  wire logic [10:0]       theta_steps,
   input  wire logic [10:0]       height_steps,
   input  wire logic              hold,
   output logic                   q_valid,
   output cst_pkg::cell_type      q_cell,
   input  wire logic              q_pop
);
   localparam int PW = cst_pkg::QUEUE_PTR_W;

   cst_pkg::cell_type mem_ff [cst_pkg::QUEUE_DEPTH];
   logic [PW-1:0]     wr_ff;
   logic [PW-1:0]     rd_ff;
   logic [PW:0]       count_ff;
   logic [PW:0]       count_in;
   logic              push;
   logic              bad;

   assign bad = ({1'b0, req_cell_theta} >= theta_steps)
             || ({1'b0, req_cell_height} >= height_steps)
             || (32'(theta_steps) > 32'(MAX_STEPS))
             || (32'(height_steps) > 32'(MAX_STEPS));

   assign req_ready = (count_ff != (PW+1)'(cst_pkg::QUEUE_DEPTH)) && !hold;
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_cell    = mem_ff[rd_ff];
   assign count_in  = count_ff + (PW+1)'(push) - (PW+1)'(q_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (q_pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= '{theta: req_cell_theta, height: req_cell_height, err: bad};
      end
   end

endmodule

`default_nettype wire

// ----- design/cst_norm.sv -----
// Normal unit: derives the cone's unit normal terms from height and radius.
`default_nettype none

module cst_norm (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        restart,
   input  wire logic [30:0] cone_height,
   input  wire logic [30:0] base_radius,
   output logic             busy,
   output cst_pkg::norm_type norm
);
   cst_pkg::norm_state_type state_ff;
   cst_pkg::norm_state_type state_in;

   logic [30:0] sh_ff;
   logic [30:0] sr_ff;
   logic [61:0] sqh_ff;
   logic [61:0] sqr_ff;
   logic [63:0] rad_ff;
   logic [63:0] root_ff;
   logic [5:0]  cnt_ff;
   logic [45:0] numh_ff;
   logic [45:0] numr_ff;
   logic [31:0] remh_ff;
   logic [31:0] remr_ff;
   logic [14:0] qh_ff;
   logic [14:0] qr_ff;

   logic [63:0] bitv;
   logic [63:0] trial;
   logic        fits;
   logic [63:0] root_next;
   logic [31:0] len_next;
   logic [31:0] len;
   logic [32:0] acch;
   logic [32:0] accr;
   logic        takeh;
   logic        taker;

   assign busy = (state_ff != cst_pkg::NRM_IDLE);
   assign norm = '{nxy: qh_ff, nz: qr_ff};

   assign bitv      = 64'd1 << {cnt_ff[4:0], 1'b0};
   assign trial     = root_ff + bitv;
   assign fits      = (rad_ff >= trial);
   assign root_next = fits ? ((root_ff >> 1) + bitv) : (root_ff >> 1);
   assign len_next  = root_next[31:0];
   assign len       = root_ff[31:0];
   assign acch      = {remh_ff, numh_ff[45]};
   assign accr      = {remr_ff, numr_ff[45]};
   assign takeh     = (acch >= {1'b0, len});
   assign taker     = (accr >= {1'b0, len});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cst_pkg::NRM_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      if (restart) begin
         state_in = cst_pkg::NRM_LOAD;
      end else begin
         unique case (state_ff)
            cst_pkg::NRM_IDLE: state_in = cst_pkg::NRM_IDLE;
            cst_pkg::NRM_LOAD: begin
               if (cone_height == '0 && base_radius == '0) begin
                  state_in = cst_pkg::NRM_IDLE;
               end else begin
                  state_in = cst_pkg::NRM_SHIFT;
               end
            end
            cst_pkg::NRM_SHIFT: begin
               if (sh_ff[30] || sr_ff[30]) begin
                  state_in = cst_pkg::NRM_SQUARE;
               end
            end
            cst_pkg::NRM_SQUARE: state_in = cst_pkg::NRM_SUM;
            cst_pkg::NRM_SUM: state_in = cst_pkg::NRM_SQRT;
            cst_pkg::NRM_SQRT: begin
               if (cnt_ff == '0) begin
                  state_in = cst_pkg::NRM_DIV;
               end
            end
            cst_pkg::NRM_DIV: begin
               if (cnt_ff == '0) begin
                  state_in = cst_pkg::NRM_IDLE;
               end
            end
            default: state_in = cst_pkg::NRM_IDLE;
         endcase
      end
   end

   // The square root settles two radicand bits per step, the divisions one quotient bit.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         cst_pkg::NRM_LOAD: begin
            sh_ff <= cone_height;
            sr_ff <= base_radius;
            qh_ff <= '0;
            qr_ff <= '0;
         end
         cst_pkg::NRM_SHIFT: begin
            if (!(sh_ff[30] || sr_ff[30])) begin
               sh_ff <= sh_ff << 1;
               sr_ff <= sr_ff << 1;
            end
         end
         cst_pkg::NRM_SQUARE: begin
            sqh_ff <= sh_ff * sh_ff;
            sqr_ff <= sr_ff * sr_ff;
         end
         cst_pkg::NRM_SUM: begin
            rad_ff  <= 64'(sqh_ff) + 64'(sqr_ff);
            root_ff <= '0;
            cnt_ff  <= 6'd31;
         end
         cst_pkg::NRM_SQRT: begin
            if (fits) begin
               rad_ff <= rad_ff - trial;
            end
            root_ff <= root_next;
            if (cnt_ff == '0) begin
               cnt_ff  <= 6'd45;
               numh_ff <= {1'b0, sh_ff, 14'd0} + 46'(len_next >> 1);
               numr_ff <= {1'b0, sr_ff, 14'd0} + 46'(len_next >> 1);
               remh_ff <= '0;
               remr_ff <= '0;
               qh_ff   <= '0;
               qr_ff   <= '0;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
         cst_pkg::NRM_DIV: begin
            numh_ff <= numh_ff << 1;
            numr_ff <= numr_ff << 1;
            remh_ff <= takeh ? 32'(acch - {1'b0, len}) : acch[31:0];
            remr_ff <= taker ? 32'(accr - {1'b0, len}) : accr[31:0];
            qh_ff   <= {qh_ff[13:0], takeh};
            qr_ff   <= {qr_ff[13:0], taker};
            cnt_ff  <= cnt_ff - 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- design/cst_div.sv -----
// Pipelined restoring divider with three lanes: angle phase, radius and height offset.
`default_nettype none

module cst_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       en,
   input  wire logic [cst_pkg::DIV_W-1:0]  num_phase,
   input  wire logic [cst_pkg::DIV_W-1:0]  num_radius,
   input  wire logic [cst_pkg::DIV_W-1:0]  num_dz,
   input  wire logic [cst_pkg::DEN_W-1:0]  den_theta,
   input  wire logic [cst_pkg::DEN_W-1:0]  den_height,
   input  wire cst_pkg::div_side_type      side_in,
   output logic [cst_pkg::DIV_W-1:0]       quo_phase,
   output logic [cst_pkg::DIV_W-1:0]       quo_radius,
   output logic [cst_pkg::DIV_W-1:0]       quo_dz,
   output cst_pkg::div_side_type           side_out
);
   localparam int N = cst_pkg::DIV_W;
   localparam int D = cst_pkg::DEN_W;

   logic [N-1:0]          num_ff  [N][3];
   logic [N-1:0]          quo_ff  [N][3];
   logic [D-1:0]          rem_ff  [N][3];
   cst_pkg::div_side_type side_ff [N];
   logic [N-1:0]          num_src0 [3];
   logic [D-1:0]          den [3];

   assign num_src0[0] = num_phase;
   assign num_src0[1] = num_radius;
   assign num_src0[2] = num_dz;
   assign den[0]      = den_theta;
   assign den[1]      = den_height;
   assign den[2]      = den_height;

   for (genvar j = 0; j < N; j++) begin : g_stage
      for (genvar l = 0; l < 3; l++) begin : g_lane
         logic [N-1:0] num_src;
         logic [N-1:0] quo_src;
         logic [D-1:0] rem_src;
         logic [D:0]   acc;
         logic         take;

         if (j == 0) begin : g_first
            assign num_src = num_src0[l];
            assign quo_src = '0;
            assign rem_src = '0;
         end else begin : g_next
            assign num_src = num_ff[j-1][l];
            assign quo_src = quo_ff[j-1][l];
            assign rem_src = rem_ff[j-1][l];
         end

         assign acc  = {rem_src, num_src[N-1]};
         assign take = (acc >= {1'b0, den[l]});

         always_ff @(posedge clock) begin
            if (en) begin
               num_ff[j][l] <= num_src << 1;
               quo_ff[j][l] <= {quo_src[N-2:0], take};
               rem_ff[j][l] <= take ? D'(acc - {1'b0, den[l]}) : acc[D-1:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[j] <= '0;
         end else if (en) begin
            side_ff[j] <= (j == 0) ? side_in : side_ff[(j == 0) ? 0 : j-1];
         end
      end
   end

   assign quo_phase  = quo_ff[N-1][0];
   assign quo_radius = quo_ff[N-1][1];
   assign quo_dz     = quo_ff[N-1][2];
   assign side_out   = side_ff[N-1];

endmodule

`default_nettype wire

// ----- design/cst_cordic.sv -----
// Pipelined CORDIC rotator: 32-bit phase in, clamped Q1.30 cosine and sine out.
`default_nettype none

module cst_cordic #(
   parameter int STAGES = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic [31:0]            phase,
   input  wire cst_pkg::cord_side_type side_in,
   output logic signed [31:0]          cos_q,
   output logic signed [31:0]          sin_q,
   output cst_pkg::cord_side_type      side_out
);
   localparam int W = cst_pkg::CORD_W;
   localparam logic signed [W-1:0] ONE = W'(64'd1 << 30);

   logic signed [W-1:0]    x_ff    [STAGES];
   logic signed [W-1:0]    y_ff    [STAGES];
   logic [31:0]            z_ff    [STAGES];
   logic                   flip_ff [STAGES];
   cst_pkg::cord_side_type side_ff [STAGES];

   logic signed [31:0]     cos_ff;
   logic signed [31:0]     sin_ff;
   cst_pkg::cord_side_type side_o_ff;

   logic                   flip0;
   logic signed [W-1:0]    xo;
   logic signed [W-1:0]    yo;

   // Phases in the second and third quarter turn are rotated by half a turn first.
   assign flip0 = phase[30] ^ phase[31];

   for (genvar j = 0; j < STAGES; j++) begin : g_stage
      logic signed [W-1:0] x_src;
      logic signed [W-1:0] y_src;
      logic [31:0]         z_src;
      logic                flip_src;
      cst_pkg::cord_side_type side_src;

      if (j == 0) begin : g_first
         assign x_src    = cst_pkg::CORDIC_GAIN;
         assign y_src    = '0;
         assign z_src    = flip0 ? (phase + 32'h80000000) : phase;
         assign flip_src = flip0;
         assign side_src = side_in;
      end else begin : g_next
         assign x_src    = x_ff[j-1];
         assign y_src    = y_ff[j-1];
         assign z_src    = z_ff[j-1];
         assign flip_src = flip_ff[j-1];
         assign side_src = side_ff[j-1];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (z_src[31]) begin
               x_ff[j] <= x_src + (y_src >>> j);
               y_ff[j] <= y_src - (x_src >>> j);
               z_ff[j] <= z_src + cst_pkg::atan_turn(j);
            end else begin
               x_ff[j] <= x_src - (y_src >>> j);
               y_ff[j] <= y_src + (x_src >>> j);
               z_ff[j] <= z_src - cst_pkg::atan_turn(j);
            end
            flip_ff[j] <= flip_src;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[j] <= '0;
         end else if (en) begin
            side_ff[j] <= side_src;
         end
      end
   end

   assign xo = flip_ff[STAGES-1] ? -x_ff[STAGES-1] : x_ff[STAGES-1];
   assign yo = flip_ff[STAGES-1] ? -y_ff[STAGES-1] : y_ff[STAGES-1];

   always_ff @(posedge clock) begin
      if (en) begin
         if (xo > ONE) begin
            cos_ff <= 32'(ONE);
         end else if (xo < -ONE) begin
            cos_ff <= 32'(-ONE);
         end else begin
            cos_ff <= 32'(xo);
         end
         if (yo > ONE) begin
            sin_ff <= 32'(ONE);
         end else if (yo < -ONE) begin
            sin_ff <= 32'(-ONE);
         end else begin
            sin_ff <= 32'(yo);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_o_ff <= '0;
      end else if (en) begin
         side_o_ff <= side_ff[STAGES-1];
      end
   end

   assign cos_q    = cos_ff;
   assign sin_q    = sin_ff;
   assign side_out = side_o_ff;

endmodule

`default_nettype wire

// ----- design/cst_back.sv -----
// Back end: expands queued cells into six vertices (one for an out-of-range cell) and runs them through the datapath.
`default_nettype none

module cst_back #(
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  wire cst_pkg::cell_type  q_cell,
   output logic                    q_pop,
   input  wire logic [30:0]        base_radius,
   input  wire logic [30:0]        cone_height,
   input  wire logic [31:0]        center_x,
   input  wire logic [31:0]        center_y,
   input  wire logic [31:0]        center_z,
   input  wire logic [10:0]        theta_steps,
   input  wire logic [10:0]        height_steps,
   input  wire cst_pkg::norm_type  norm,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_pos_x,
   output logic signed [31:0]      rsp_pos_y,
   output logic signed [31:0]      rsp_pos_z,
   output logic signed [15:0]      rsp_norm_x,
   output logic signed [15:0]      rsp_norm_y,
   output logic signed [15:0]      rsp_norm_z,
   output logic                    rsp_cell_error,
   output logic                    rsp_last_vertex
);
   localparam int N = cst_pkg::DIV_W;

   logic        en;
   logic        issue;
   logic        last_k;
   logic [2:0]  k_ff;
   logic [2:0]  k_in;

   // Issue stage.
   logic        s0_vld_ff;
   logic [10:0] s0_a_ff;
   logic [10:0] s0_b_ff;
   logic        s0_err_ff;
   logic        s0_last_ff;

   // Numerator stage.
   logic [N-1:0]          s1_ph_ff;
   logic [N-1:0]          s1_rn_ff;
   logic [N-1:0]          s1_dn_ff;
   cst_pkg::div_side_type s1_side_ff;
   logic [10:0]           diff;

   logic [N-1:0]           quo_phase;
   logic [N-1:0]           quo_radius;
   logic [N-1:0]           quo_dz;
   cst_pkg::div_side_type  div_side;
   cst_pkg::cord_side_type cord_in;
   logic signed [31:0]     cos_q;
   logic signed [31:0]     sin_q;
   cst_pkg::cord_side_type cord_side;

   // Multiply stage.
   logic signed [63:0] pxp_ff;
   logic signed [63:0] pyp_ff;
   logic signed [63:0] nxp_ff;
   logic signed [63:0] nyp_ff;
   logic [30:0]        m_dz_ff;
   logic               m_vld_ff;
   logic               m_err_ff;
   logic               m_last_ff;

   logic signed [31:0] rsp_pos_x_ff;
   logic signed [31:0] rsp_pos_y_ff;
   logic signed [31:0] rsp_pos_z_ff;
   logic signed [15:0] rsp_norm_x_ff;
   logic signed [15:0] rsp_norm_y_ff;
   logic signed [15:0] rsp_norm_z_ff;
   logic               rsp_err_ff;
   logic               rsp_last_ff;
   logic               rsp_valid_ff;

   logic signed [33:0] rx;
   logic signed [33:0] ry;
   logic signed [33:0] nx;
   logic signed [33:0] ny;

   // The whole pipeline advances unless a result waits at the output.
   assign en     = !rsp_valid_ff || rsp_ready;
   assign issue  = en && q_valid;
   assign last_k = q_cell.err || (k_ff == 3'(cst_pkg::VERTS - 1));
   assign q_pop  = issue && last_k;
   assign k_in   = !issue ? k_ff : (last_k ? 3'd0 : k_ff + 3'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff      <= '0;
         s0_vld_ff <= 1'b0;
      end else begin
         k_ff <= k_in;
         if (en) begin
            s0_vld_ff <= q_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_a_ff    <= {1'b0, q_cell.theta} + 11'(cst_pkg::corner_t(k_ff));
         s0_b_ff    <= {1'b0, q_cell.height} + 11'(cst_pkg::corner_h(k_ff));
         s0_err_ff  <= q_cell.err;
         s0_last_ff <= last_k;
      end
   end

   assign diff = height_steps - s0_b_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ph_ff <= {s0_a_ff, 32'd0};
         s1_rn_ff <= N'(base_radius) * N'(diff);
         s1_dn_ff <= N'(cone_height) * N'(s0_b_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_side_ff <= '0;
      end else if (en) begin
         s1_side_ff <= '{vld: s0_vld_ff, err: s0_err_ff, last: s0_last_ff};
      end
   end

   cst_div u_div (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .num_phase  (s1_ph_ff),
      .num_radius (s1_rn_ff),
      .num_dz     (s1_dn_ff),
      .den_theta  (theta_steps),
      .den_height (height_steps),
      .side_in    (s1_side_ff),
      .quo_phase  (quo_phase),
      .quo_radius (quo_radius),
      .quo_dz     (quo_dz),
      .side_out   (div_side)
   );

   assign cord_in = '{vld: div_side.vld, err: div_side.err, last: div_side.last,
                      radius: quo_radius[30:0], dz: quo_dz[30:0]};

   cst_cordic #(
      .STAGES (CORDIC_STAGES)
   ) u_cordic (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .phase    (quo_phase[31:0]),
      .side_in  (cord_in),
      .cos_q    (cos_q),
      .sin_q    (sin_q),
      .side_out (cord_side)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         pxp_ff    <= $signed({1'b0, cord_side.radius}) * cos_q;
         pyp_ff    <= $signed({1'b0, cord_side.radius}) * sin_q;
         nxp_ff    <= $signed({17'd0, norm.nxy}) * cos_q;
         nyp_ff    <= $signed({17'd0, norm.nxy}) * sin_q;
         m_dz_ff   <= cord_side.dz;
         m_err_ff  <= cord_side.err;
         m_last_ff <= cord_side.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else if (en) begin
         m_vld_ff <= cord_side.vld;
      end
   end

   assign rx = cst_pkg::round_q30(pxp_ff);
   assign ry = cst_pkg::round_q30(pyp_ff);
   assign nx = cst_pkg::round_q30(nxp_ff);
   assign ny = cst_pkg::round_q30(nyp_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         if (m_err_ff) begin
            rsp_pos_x_ff  <= '0;
            rsp_pos_y_ff  <= '0;
            rsp_pos_z_ff  <= '0;
            rsp_norm_x_ff <= '0;
            rsp_norm_y_ff <= '0;
            rsp_norm_z_ff <= '0;
            rsp_err_ff    <= 1'b1;
            rsp_last_ff   <= 1'b1;
         end else begin
            rsp_pos_x_ff  <= cst_pkg::sat32(35'($signed(center_x)) + 35'(rx));
            rsp_pos_y_ff  <= cst_pkg::sat32(35'($signed(center_y)) + 35'(ry));
            rsp_pos_z_ff  <= cst_pkg::sat32(35'($signed(center_z)) + {4'd0, m_dz_ff});
            rsp_norm_x_ff <= nx[15:0];
            rsp_norm_y_ff <= ny[15:0];
            rsp_norm_z_ff <= {1'b0, norm.nz};
            rsp_err_ff    <= 1'b0;
            rsp_last_ff   <= m_last_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= m_vld_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x       = rsp_pos_x_ff;
   assign rsp_pos_y       = rsp_pos_y_ff;
   assign rsp_pos_z       = rsp_pos_z_ff;
   assign rsp_norm_x      = rsp_norm_x_ff;
   assign rsp_norm_y      = rsp_norm_y_ff;
   assign rsp_norm_z      = rsp_norm_z_ff;
   assign rsp_cell_error  = rsp_err_ff;
   assign rsp_last_vertex = rsp_last_ff;

endmodule

`default_nettype wire
